[sv/spfsc_pkg.sv]
// ----------------------------------------------------------------------------
// spfsc_pkg
// Shared types and constants for the sensor packet framer with sum check.
// ----------------------------------------------------------------------------
package spfsc_pkg;

	localparam int FRAME_LENGTH = 67;
	localparam int POS_W        = 7;
	localparam int SUM_W        = 16;
	localparam int CNT_W        = 16;
	localparam int BYTE_W       = 8;

	// output word layout
	localparam int TDATA_W = 56;
	localparam int TUSER_W = 2;

	localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(FRAME_LENGTH - 1);
	localparam logic [POS_W-1:0]  CHK_HI_POS  = POS_W'(FRAME_LENGTH - 2);
	localparam logic [POS_W-1:0]  FIRST_BODY  = POS_W'(1);
	localparam logic [BYTE_W-1:0] HEADER_RST  = 8'd200;

	typedef enum logic {
		PH_WAIT = 1'b0,
		PH_READ = 1'b1
	} phase_t;

	typedef struct packed {
		logic              header_seen;
		logic              in_frame;
		logic [POS_W-1:0]  byte_position;
		logic [BYTE_W-1:0] data_out;
		logic              frame_last;
		logic              checksum_good;
		logic              message_ready;
		logic [CNT_W-1:0]  header_error_total;
		logic [CNT_W-1:0]  checksum_error_total;
	} result_t;

endpackage

[sv/spfsc_core.sv]
// ----------------------------------------------------------------------------
// spfsc_core
// Frame state, running sum and error counters; one byte per load.
// ----------------------------------------------------------------------------
module spfsc_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,        // byte in s1 moves to output reg
	input  logic [spfsc_pkg::BYTE_W-1:0]   rx_byte_s1,
	input  logic [spfsc_pkg::BYTE_W-1:0]   header_byte,
	output spfsc_pkg::result_t             res
);
	import spfsc_pkg::*;

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic [BYTE_W-1:0] held_q, held_d;
	logic [CNT_W-1:0]  herr_q, herr_d;
	logic [CNT_W-1:0]  cerr_q, cerr_d;
	logic              avail_q, avail_d;
	logic              is_hdr;
	logic              at_last;
	logic              sum_match;

	assign is_hdr    = (rx_byte_s1 == header_byte);
	assign at_last   = (pos_q >= LAST_POS);
	assign sum_match = ({held_q, rx_byte_s1} == sum_q);

	// next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_WAIT: begin
				if (is_hdr) begin
					phase_d = PH_READ;
				end
			end
			PH_READ: begin
				if (at_last) begin
					phase_d = PH_WAIT;
				end
			end
			default: phase_d = PH_WAIT;
		endcase
	end

	// datapath and result
	always_comb begin
		pos_d   = pos_q;
		sum_d   = sum_q;
		held_d  = held_q;
		herr_d  = herr_q;
		cerr_d  = cerr_q;
		avail_d = avail_q;

		res               = '0;
		res.data_out      = rx_byte_s1;

		case (phase_q)
			PH_WAIT: begin
				if (is_hdr) begin
					res.header_seen = 1'b1;
					res.in_frame    = 1'b1;
					pos_d           = FIRST_BODY;
					sum_d           = {{(SUM_W-BYTE_W){1'b0}}, rx_byte_s1};
				end else begin
					herr_d = herr_q + 1'b1;
				end
			end
			PH_READ: begin
				res.in_frame      = 1'b1;
				res.byte_position = pos_q;
				if (at_last) begin
					res.frame_last = 1'b1;
					pos_d          = '0;
					if (sum_match) begin
						res.checksum_good = 1'b1;
						avail_d           = 1'b1;
					end else begin
						avail_d = 1'b0;
						cerr_d  = cerr_q + 1'b1;
					end
				end else begin
					if (pos_q < CHK_HI_POS) begin
						sum_d = sum_q + {{(SUM_W-BYTE_W){1'b0}}, rx_byte_s1};
					end else begin
						held_d = rx_byte_s1;
					end
					pos_d = pos_q + 1'b1;
				end
			end
			default: ;
		endcase

		res.message_ready        = avail_d;
		res.header_error_total   = herr_d;
		res.checksum_error_total = cerr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			pos_q   <= '0;
			sum_q   <= '0;
			held_q  <= '0;
			herr_q  <= '0;
			cerr_q  <= '0;
			avail_q <= 1'b0;
		end else if (load) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			held_q  <= held_d;
			herr_q  <= herr_d;
			cerr_q  <= cerr_d;
			avail_q <= avail_d;
		end
	end

endmodule

[sv/spfsc_out_reg.sv]
// ----------------------------------------------------------------------------
// spfsc_out_reg
// Result register with valid/ready toward the downstream receiver.
// ----------------------------------------------------------------------------
module spfsc_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,   // s1 holds a byte
	input  spfsc_pkg::result_t  res,
	output logic                load,       // s1 result is captured this cycle
	output logic                out_valid,
	input  logic                out_ready,
	output spfsc_pkg::result_t  res_q
);
	import spfsc_pkg::*;

	logic valid_q;

	assign load      = in_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

[sv/sensor_packet_framer_sum_check_top.sv]
// ----------------------------------------------------------------------------
// sensor_packet_framer_sum_check_top
// Header/length framer with a 16-bit additive checksum over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per word. While waiting, a byte equal to
//   the header register opens a frame; any other byte bumps the header error
//   count. Frame bytes are numbered 0 (header) to FRAME_LENGTH-1. The last two
//   bytes are the big-endian sum of all earlier frame bytes.
//   m_axis returns one word per input word: the byte, its frame index and
//   flags, the message-ready flag and both wrapping error counts.
//   cfg writes the header byte; cfg_ready is always high. Write it only
//   while no word is in flight.
// Timing:
//   Each word passes the input register s1, then the result register. One word
//   per cycle while m_axis_tready is high; the running sum, index and counters
//   are single registers updated as each word leaves s1.
// Reset:
//   arst_n clears frame state, sum, counters and the ready flag; the header
//   register returns to 200. No output word is pending after reset.
// Stall:
//   When m_axis_tready is low the result word holds, s1 holds, and
//   s_axis_tready drops once s1 is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sensor_packet_framer_sum_check_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// input byte stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [6:0] byte_position, [14:7] data_out, [15] checksum_good,
	// [16] message_ready, [32:17] header_error_total,
	// [48:33] checksum_error_total, [55:49] zero
	output logic [spfsc_pkg::TDATA_W-1:0]     m_axis_tdata,
	output logic [spfsc_pkg::TUSER_W-1:0]     m_axis_tuser,  // [0] header_seen, [1] in_frame
	output logic                              m_axis_tlast,  // frame_last
	// header byte register write
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [7:0]                        cfg_data
);
	import spfsc_pkg::*;

	logic [BYTE_W-1:0] header_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic              load;
	result_t           res;
	result_t           res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RST;
		end else if (cfg_valid && cfg_ready) begin
			header_q <= cfg_data;
		end
	end

	// s1 frees up in the same cycle its word moves on
	assign s_axis_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			rx_byte_s1 <= s_axis_tdata;
		end
	end

	spfsc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.rx_byte_s1 (rx_byte_s1),
		.header_byte(header_q),
		.res        (res)
	);

	spfsc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.res      (res),
		.load     (load),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.res_q    (res_q)
	);

	assign m_axis_tdata = {
		{(TDATA_W-49){1'b0}},
		res_q.checksum_error_total,
		res_q.header_error_total,
		res_q.message_ready,
		res_q.checksum_good,
		res_q.data_out,
		res_q.byte_position
	};
	assign m_axis_tuser = {res_q.in_frame, res_q.header_seen};
	assign m_axis_tlast = res_q.frame_last;

endmodule

[sv/spfsc_checker.sv]
// ----------------------------------------------------------------------------
// spfsc_checker
// Port-level checks on the framer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module spfsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [spfsc_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic [spfsc_pkg::TUSER_W-1:0] m_axis_tuser,
	input logic                          m_axis_tlast
);
	import spfsc_pkg::*;

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed under stall");

	// frame end only inside a frame, at the final index
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			m_axis_tuser[1] && (m_axis_tdata[6:0] >= LAST_POS))
		else $error("frame end outside a frame");

	// header word opens at index 0
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1] && (m_axis_tdata[6:0] == '0))
		else $error("header word with wrong index");

	// good checksum only on frame end, and it raises message ready
	a_good: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tlast && m_axis_tdata[16])
		else $error("checksum good without frame end or ready flag");

	// bytes outside a frame carry index 0
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata[6:0] == '0) && !m_axis_tlast)
		else $error("index set outside a frame");

endmodule

bind sensor_packet_framer_sum_check_top spfsc_checker u_spfsc_checker (.*);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor packet framer with sum check.
//
// Byte words go in on s_axis from a pending queue. A local copy of the framer
// state predicts one result word per accepted byte. The monitor checks every
// result word, field by field, against the oldest prediction. Traffic is mostly
// whole frames with good or bad sums, plus stray bytes, cut-off frames and
// noise, under three idle mixes. The header register is rewritten between
// phases.
// ----------------------------------------------------------------------------
module tb;

	import spfsc_pkg::*;

	localparam int CLK_HALF        = 4;        // 8 ns period
	localparam int CYCLE_LIMIT     = 1000000;  // well above the slowest legal run
	localparam int RX_STALL_CYCLES = 150;      // long enough to back up s1 and s_axis
	localparam int PAYLOAD_LAST    = FRAME_LENGTH - 3;  // last byte inside the sum

	// payload styles for generated frames
	typedef enum int {
		PL_RANDOM,
		PL_ALL_ONES,   // largest sum a frame can carry
		PL_HEADERS,    // header value sprinkled through the body
		PL_ZEROS
	} payload_t;

	// ---------------------------------------------------------------- DUT I/O
	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                s_axis_tvalid  = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata   = '0;   // [7:0] rx_byte
	logic                m_axis_tvalid;
	logic                m_axis_tready  = 1'b0;
	// [6:0] byte_position, [14:7] data_out, [15] checksum_good,
	// [16] message_ready, [32:17] header_error_total,
	// [48:33] checksum_error_total, [55:49] zero
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic [TUSER_W-1:0]  m_axis_tuser;          // [0] header_seen, [1] in_frame
	logic                m_axis_tlast;          // frame_last
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_data       = '0;

	sensor_packet_framer_sum_check_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------- bench bookkeeping
	logic [7:0] pending_bytes[$];   // bytes still to be offered on s_axis
	result_t    want_results[$];    // predicted result words, oldest first

	int  src_idle_pct   = 0;        // chance per cycle that the sender holds back
	int  snk_idle_pct   = 0;        // chance per cycle that the receiver holds back
	int  rx_stall_id    = 0;        // bumped to request one long receiver stall
	int  rx_stall_ack   = 0;
	int  rx_stall_left  = 0;
	bit  in_taken       = 1'b0;     // s_axis word accepted at the last rising edge
	int  cycle_count    = 0;
	int  mismatches     = 0;
	int  words_checked  = 0;
	int  frames_good    = 0;
	int  frames_bad     = 0;
	int  cfg_writes     = 0;

	// ------------------------------------------------------ framer shadow state
	logic [7:0]  header_cfg;        // header register as last written
	phase_t      frm_phase;
	logic [6:0]  frm_pos;           // index of the next frame byte
	logic [15:0] frm_sum;
	logic [7:0]  chk_hi;            // high checksum byte, held until the last byte
	logic [15:0] hdr_errs;
	logic [15:0] sum_errs;
	logic        msg_flag;

	// Advance the shadow framer by one byte and return the word it should emit.
	function automatic result_t predict_word(input logic [7:0] b);
		result_t r;
		r          = '0;
		r.data_out = b;
		if (frm_phase == PH_WAIT) begin
			if (b == header_cfg) begin
				r.header_seen = 1'b1;
				r.in_frame    = 1'b1;
				frm_phase     = PH_READ;
				frm_pos       = FIRST_BODY;
				frm_sum       = {8'h00, b};
			end else begin
				hdr_errs = hdr_errs + 16'd1;
			end
		end else begin
			r.in_frame      = 1'b1;
			r.byte_position = frm_pos;
			if (frm_pos >= LAST_POS) begin
				// out-of-range index behaves as the last byte too
				r.frame_last = 1'b1;
				if ({chk_hi, b} == frm_sum) begin
					r.checksum_good = 1'b1;
					msg_flag        = 1'b1;
				end else begin
					msg_flag = 1'b0;
					sum_errs = sum_errs + 16'd1;
				end
				frm_phase = PH_WAIT;
				frm_pos   = '0;
			end else begin
				if (frm_pos < CHK_HI_POS)
					frm_sum = frm_sum + {8'h00, b};
				else
					chk_hi = b;
				frm_pos = frm_pos + 7'd1;
			end
		end
		r.message_ready        = msg_flag;
		r.header_error_total   = hdr_errs;
		r.checksum_error_total = sum_errs;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
	                           input logic [15:0] seen);
		if (want !== seen) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------ driver
	// Moves at the falling edge. A word stays up until taken; a new one (or an
	// idle cycle) is only chosen once the current word is gone.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending_bytes.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver ready. A stall request turns into a long hold-off counted here.
	always @(negedge clk) begin
		if (rx_stall_ack != rx_stall_id) begin
			rx_stall_ack  = rx_stall_id;
			rx_stall_left = RX_STALL_CYCLES;
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// ----------------------------------------------------------------- monitor
	// Samples at the rising edge. The result word is checked before this
	// edge's input word is predicted, so order within the queue holds.
	always @(posedge clk) begin : monitor
		result_t want;
		result_t got;
		cycle_count++;
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.header_seen          = m_axis_tuser[0];
			got.in_frame             = m_axis_tuser[1];
			got.byte_position        = m_axis_tdata[6:0];
			got.data_out             = m_axis_tdata[14:7];
			got.checksum_good        = m_axis_tdata[15];
			got.message_ready        = m_axis_tdata[16];
			got.header_error_total   = m_axis_tdata[32:17];
			got.checksum_error_total = m_axis_tdata[48:33];
			got.frame_last           = m_axis_tlast;
			if (want_results.size() == 0) begin
				$error("result word with no prediction waiting: tdata 0x%0h", m_axis_tdata);
				mismatches++;
			end else begin
				want = want_results.pop_front();
				words_checked++;
				check_field("header_seen", 16'(want.header_seen), 16'(got.header_seen));
				check_field("in_frame", 16'(want.in_frame), 16'(got.in_frame));
				check_field("byte_position", 16'(want.byte_position),
				            16'(got.byte_position));
				check_field("data_out", 16'(want.data_out), 16'(got.data_out));
				check_field("frame_last", 16'(want.frame_last), 16'(got.frame_last));
				check_field("checksum_good", 16'(want.checksum_good),
				            16'(got.checksum_good));
				check_field("message_ready", 16'(want.message_ready),
				            16'(got.message_ready));
				check_field("header_error_total", want.header_error_total,
				            got.header_error_total);
				check_field("checksum_error_total", want.checksum_error_total,
				            got.checksum_error_total);
				check_field("tdata pad", 16'h0000, 16'(m_axis_tdata[TDATA_W-1:49]));
				if (want.frame_last && want.checksum_good)
					frames_good++;
				else if (want.frame_last)
					frames_bad++;
			end
		end
		if (in_taken)
			want_results.push_back(predict_word(s_axis_tdata));
	end

	// ---------------------------------------------------------------- watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d words still predicted",
		         cycle_count, want_results.size());
		$display("sensor_packet_framer_sum_check_top test failed");
		$finish;
	end

	// --------------------------------------------------------- stimulus helpers
	task automatic push_stray();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == header_cfg);
		pending_bytes.push_back(b);
	endtask

	// Whole frame: header, body, big-endian sum over everything but the tail.
	// A bad frame gets a nonzero error pattern folded into the sum bytes.
	task automatic push_frame(input bit good, input payload_t style);
		logic [7:0]  fb[FRAME_LENGTH];
		logic [15:0] sum;
		logic [15:0] tail;
		fb[0] = header_cfg;
		sum   = {8'h00, header_cfg};
		for (int i = 1; i <= PAYLOAD_LAST; i++) begin
			case (style)
				PL_ALL_ONES: fb[i] = 8'hFF;
				PL_ZEROS:    fb[i] = 8'h00;
				PL_HEADERS:  fb[i] = ($urandom_range(3) == 0) ? header_cfg
				                                              : 8'($urandom_range(255));
				default:     fb[i] = 8'($urandom_range(255));
			endcase
			sum = sum + {8'h00, fb[i]};
		end
		tail = good ? sum : sum ^ 16'($urandom_range(1, 65535));
		fb[FRAME_LENGTH-2] = tail[15:8];
		fb[FRAME_LENGTH-1] = tail[7:0];
		for (int i = 0; i < FRAME_LENGTH; i++)
			pending_bytes.push_back(fb[i]);
	endtask

	// Mostly well-formed frames with random content; the rest is cut-off
	// frames and raw noise that may hit the header value.
	task automatic push_traffic(input int n_bytes);
		int start;
		int kind;
		int cut;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < n_bytes) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				repeat ($urandom_range(2)) push_stray();
				push_frame($urandom_range(99) < 75, payload_t'($urandom_range(3)));
			end else if (kind < 85) begin
				// broken frame: the next bytes are swallowed as its remainder
				pending_bytes.push_back(header_cfg);
				cut = $urandom_range(1, FRAME_LENGTH - 2);
				repeat (cut) pending_bytes.push_back(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 8)) pending_bytes.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	// Sender pause: hold off until every predicted word has come back.
	task automatic drain();
		do @(posedge clk);
		while (pending_bytes.size() != 0 || s_axis_tvalid || want_results.size() != 0);
		repeat (4) @(posedge clk);  // keep a margin after the last result word
	endtask

	task automatic write_header(input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		header_cfg = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// -------------------------------------------------------------- main flow
	initial begin
		header_cfg = HEADER_RST;
		frm_phase  = PH_WAIT;
		frm_pos    = '0;
		frm_sum    = '0;
		chk_hi     = '0;
		hdr_errs   = '0;
		sum_errs   = '0;
		msg_flag   = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset header value, extreme and near-header strays,
		// largest sum, a header byte inside the body, flag set / hold / clear
		src_idle_pct = 24;
		snk_idle_pct = 81;
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(8'h55);
		pending_bytes.push_back(8'hAA);
		pending_bytes.push_back(8'd199);
		pending_bytes.push_back(8'd201);
		push_frame(1'b1, PL_ALL_ONES);
		pending_bytes.push_back(8'h00);
		push_frame(1'b1, PL_HEADERS);
		push_frame(1'b0, PL_ZEROS);
		pending_bytes.push_back(8'hFF);
		push_frame(1'b1, PL_RANDOM);
		drain();

		// header 0, sender mostly busy, receiver mostly idle
		write_header(8'h00);
		push_traffic(310);
		drain();

		// header 255, the other way round
		src_idle_pct = 81;
		snk_idle_pct = 24;
		write_header(8'hFF);
		push_traffic(310);
		drain();

		// random header, no idling, plus one long receiver hold-off while the
		// sender keeps offering, so s1 fills and s_axis backs up
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_header(8'($urandom_range(1, 254)));
		push_traffic(310);
		repeat (20) @(posedge clk);
		rx_stall_id++;
		drain();

		$display("checked %0d result words: %0d good-sum frames, %0d bad-sum frames,",
		         words_checked, frames_good, frames_bad);
		$display("%0d header writes, three idle mixes and one long stall, %0d cycles",
		         cfg_writes, cycle_count);
		if (mismatches == 0)
			$display("sensor_packet_framer_sum_check_top test passed");
		else
			$display("sensor_packet_framer_sum_check_top test failed");
		$finish;
	end

endmodule

[sim.f]
sv/spfsc_pkg.sv
sv/spfsc_core.sv
sv/spfsc_out_reg.sv
sv/sensor_packet_framer_sum_check_top.sv
sv/spfsc_checker.sv
verif/tb.sv
